>>> src/plane_box_corner_contacts_unit_macros.svh
// ----------------------------------------------------------------------------
// plane_box_corner_contacts_unit assertion macros
// Shorthand for clocked implication checks on the top level.
// ----------------------------------------------------------------------------
`ifndef PLANE_BOX_CORNER_CONTACTS_UNIT_MACROS_SVH
`define PLANE_BOX_CORNER_CONTACTS_UNIT_MACROS_SVH

// same-cycle implication
`define PBCC_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define PBCC_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> src/pbcc_pkg.sv
// ----------------------------------------------------------------------------
// pbcc_pkg
// Shared widths, types and helpers for the plane/box corner contact unit.
// ----------------------------------------------------------------------------
package pbcc_pkg;

    localparam int QDEPTH_DEF = 2;

    localparam int RW   = 34;          // rotation matrix entry, Q28
    localparam int CW   = 36;          // signed row sum per corner
    localparam int FW   = CW + 33;     // full offset product
    localparam int COW  = 42;          // wide corner coordinate
    localparam int MW   = COW + 17;    // depth term product
    localparam int DW   = COW + 19;    // exact depth, Q30
    localparam int DQW  = DW - 14;     // depth, Q16
    localparam int LOW  = 24;          // low part of split depth
    localparam int HIW  = DQW - LOW;
    localparam int PW   = 41;          // normal times depth part
    localparam int SW   = PW + LOW + 1;
    localparam int AJW  = SW - 14;
    localparam int SATW = AJW + 1;

    localparam logic signed [RW-1:0] MAT_ONE     = RW'(64'sd268435456);
    localparam logic [2:0]           LAST_CORNER = 3'd7;

    typedef enum logic [2:0] {
        REG_PX = 3'd0,
        REG_PY = 3'd1,
        REG_PZ = 3'd2,
        REG_NX = 3'd3,
        REG_NY = 3'd4,
        REG_NZ = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
    } t_plane;

    typedef struct packed {
        logic [8:0][RW-1:0] m;      // row-major
        logic [2:0][31:0]   ctr;
        logic [30:0]        half;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic               hit;
        logic [2:0]         corner;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic [30:0]        depth;
        logic               last;
    } t_result;

    function automatic logic signed [CW-1:0] f_sgn(input logic [RW-1:0] v, input logic neg);
        logic signed [CW-1:0] e;
        e = CW'($signed(v));
        return neg ? -e : e;
    endfunction

    function automatic logic [31:0] f_sat32(input logic signed [SATW-1:0] v);
        logic signed [SATW-1:0] mx;
        logic signed [SATW-1:0] mn;
        mx = SATW'($signed(32'h7fffffff));
        mn = SATW'($signed(32'h80000000));
        if (v > mx) return 32'h7fffffff;
        if (v < mn) return 32'h80000000;
        return v[31:0];
    endfunction

endpackage

>>> src/plane_box_corner_contacts_unit.sv
// ----------------------------------------------------------------------------
// plane_box_corner_contacts_unit
// Contacts of a rotated cube against a configured plane.
// ----------------------------------------------------------------------------
// Each box beat yields its penetrating corners as contact beats in corner
// order, the final one with tlast, or a single tuser=0 beat with tlast when
// no corner penetrates. The corner pipeline issues one corner per cycle from
// the job queue unless the result side stalls, and the emitter sends a held
// final contact while it takes the next box's first corner, so boxes follow
// back to back.
// Plane registers are to be written over APB only while no box is in flight;
// the block itself does not enforce this.
`include "plane_box_corner_contacts_unit_macros.svh"

module plane_box_corner_contacts_unit #(
    parameter int QDEPTH = pbcc_pkg::QDEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // center_x, center_y, center_z, half_size, rot_w, rot_x, rot_y, rot_z
    input  logic [191:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // corner, contact_x, contact_y, contact_z, depth
    output logic [135:0] m_tdata,
    // hit
    output logic [0:0]   m_tuser,
    output logic         m_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import pbcc_pkg::*;

    t_plane  r_plane;
    t_job    w_fjob, w_qjob;
    t_q_stat w_qstat;
    t_result w_res;
    logic    w_push, w_pop, w_cfg_we;

    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane.px <= '0;
            r_plane.py <= '0;
            r_plane.pz <= '0;
            r_plane.nx <= '0;
            r_plane.ny <= 16'sd16384;
            r_plane.nz <= '0;
        end else if (w_cfg_we) begin
            case (t_reg_idx'(paddr[4:2]))
                REG_PX:  r_plane.px <= pwdata;
                REG_PY:  r_plane.py <= pwdata;
                REG_PZ:  r_plane.pz <= pwdata;
                REG_NX:  r_plane.nx <= pwdata[15:0];
                REG_NY:  r_plane.ny <= pwdata[15:0];
                REG_NZ:  r_plane.nz <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[4:2]))
            REG_PX:  prdata = r_plane.px;
            REG_PY:  prdata = r_plane.py;
            REG_PZ:  prdata = r_plane.pz;
            REG_NX:  prdata = {16'h0, r_plane.nx};
            REG_NY:  prdata = {16'h0, r_plane.ny};
            REG_NZ:  prdata = {16'h0, r_plane.nz};
            default: prdata = '0;
        endcase
    end

    pbcc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_data  (s_tdata),
        .i_full  (w_qstat.full),
        .o_push  (w_push),
        .o_job   (w_fjob)
    );

    pbcc_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_fjob),
        .i_pop   (w_pop),
        .o_job   (w_qjob),
        .o_stat  (w_qstat)
    );

    pbcc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (w_qjob),
        .i_stat  (w_qstat),
        .o_pop   (w_pop),
        .i_plane (r_plane),
        .i_ready (m_tready),
        .o_valid (m_tvalid),
        .o_res   (w_res)
    );

    assign m_tdata    = {6'h0, w_res.depth, w_res.cz, w_res.cy, w_res.cx, w_res.corner};
    assign m_tuser[0] = w_res.hit;
    assign m_tlast    = w_res.last;

    `PBCC_ASSERT_IMP(a_miss_is_last, m_tvalid && !m_tuser[0], m_tlast && (m_tdata == '0), "miss beat must be a bare last beat")
    `PBCC_ASSERT_IMP(a_no_push_full, w_push, !w_qstat.full, "job pushed into full queue")
    `PBCC_ASSERT_IMP(a_no_pop_empty, w_pop, !w_qstat.empty, "job popped from empty queue")
    `PBCC_ASSERT_NXT(a_accept_push, s_tvalid && s_tready, w_push || w_qstat.full, "accepted box not offered to queue")

endmodule

>>> src/pbcc_queue.sv
// ----------------------------------------------------------------------------
// pbcc_queue
// Small FIFO of box jobs between the front end and the corner pipeline.
// ----------------------------------------------------------------------------
module pbcc_queue #(
    parameter int DEPTH = pbcc_pkg::QDEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pbcc_pkg::t_job   i_job,
    input  logic             i_pop,
    output pbcc_pkg::t_job   o_job,
    output pbcc_pkg::t_q_stat o_stat
);
    import pbcc_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);

    t_job            r_mem [DEPTH];
    logic [AW-1:0]   r_wp;
    logic [AW-1:0]   r_rp;
    logic [CNTW-1:0] r_cnt;

    assign o_job       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == CNTW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> src/pbcc_front.sv
// ----------------------------------------------------------------------------
// pbcc_front
// Accepts box beats, forms quaternion products and the rotation matrix.
// ----------------------------------------------------------------------------
module pbcc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [191:0]   i_data,
    input  logic           i_full,
    output logic           o_push,
    output pbcc_pkg::t_job o_job
);
    import pbcc_pkg::*;

    logic               r_fv;
    logic [2:0][31:0]   r_ctr;
    logic [30:0]        r_half;
    logic signed [31:0] r_xx, r_yy, r_zz, r_xy, r_wz, r_xz, r_wy, r_yz, r_wx;

    logic               accept;
    logic signed [15:0] q_w, q_x, q_y, q_z;
    logic signed [RW-1:0] e_xx, e_yy, e_zz, e_xy, e_wz, e_xz, e_wy, e_yz, e_wx;

    assign q_w = i_data[142:127];
    assign q_x = i_data[158:143];
    assign q_y = i_data[174:159];
    assign q_z = i_data[190:175];

    assign o_ready = !r_fv || !i_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = r_fv && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else begin
            r_fv <= accept || (r_fv && i_full);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ctr[0] <= i_data[31:0];
            r_ctr[1] <= i_data[63:32];
            r_ctr[2] <= i_data[95:64];
            r_half   <= i_data[126:96];
            r_xx <= q_x * q_x;
            r_yy <= q_y * q_y;
            r_zz <= q_z * q_z;
            r_xy <= q_x * q_y;
            r_wz <= q_w * q_z;
            r_xz <= q_x * q_z;
            r_wy <= q_w * q_y;
            r_yz <= q_y * q_z;
            r_wx <= q_w * q_x;
        end
    end

    always_comb begin
        e_xx = RW'(r_xx);
        e_yy = RW'(r_yy);
        e_zz = RW'(r_zz);
        e_xy = RW'(r_xy);
        e_wz = RW'(r_wz);
        e_xz = RW'(r_xz);
        e_wy = RW'(r_wy);
        e_yz = RW'(r_yz);
        e_wx = RW'(r_wx);
        o_job.m[0] = MAT_ONE - ((e_yy + e_zz) <<< 1);
        o_job.m[1] = (e_xy - e_wz) <<< 1;
        o_job.m[2] = (e_xz + e_wy) <<< 1;
        o_job.m[3] = (e_xy + e_wz) <<< 1;
        o_job.m[4] = MAT_ONE - ((e_xx + e_zz) <<< 1);
        o_job.m[5] = (e_yz - e_wx) <<< 1;
        o_job.m[6] = (e_xz - e_wy) <<< 1;
        o_job.m[7] = (e_yz + e_wx) <<< 1;
        o_job.m[8] = MAT_ONE - ((e_xx + e_yy) <<< 1);
        o_job.ctr  = r_ctr;
        o_job.half = r_half;
    end

endmodule

>>> src/pbcc_back.sv
// ----------------------------------------------------------------------------
// pbcc_back
// Corner pipeline: one corner per cycle, unless stalled, through offset, depth
// and contact stages; an emitter holds one contact back to mark the last one.
// ----------------------------------------------------------------------------
module pbcc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pbcc_pkg::t_job    i_job,
    input  pbcc_pkg::t_q_stat i_stat,
    output logic              o_pop,
    input  pbcc_pkg::t_plane  i_plane,
    input  logic              i_ready,
    output logic              o_valid,
    output pbcc_pkg::t_result o_res
);
    import pbcc_pkg::*;

    logic [2:0] r_k;
    logic       en, issue, consume, o_free;

    // stage A: row sums
    logic                 r_av;
    logic signed [CW-1:0] r_ac [3];
    logic [2:0][31:0]     r_actr;
    logic [30:0]          r_ah;
    logic [2:0]           r_ak;
    // stage B: offset partial products
    logic                   r_bv;
    logic signed [CW+15:0]  r_bph [3];
    logic signed [CW+16:0]  r_bpl [3];
    logic [2:0][31:0]       r_bctr;
    logic [2:0]             r_bk;
    // stage C: corners
    logic                  r_cv;
    logic signed [COW-1:0] r_ccor [3];
    logic [2:0]            r_ck;
    // stage D: depth terms
    logic                  r_dv;
    logic signed [MW-1:0]  r_dm [3];
    logic signed [COW-1:0] r_dcor [3];
    logic [2:0]            r_dk;
    // stage E: depth
    logic                  r_ev;
    logic signed [DW-1:0]  r_ed;
    logic signed [COW-1:0] r_ecor [3];
    logic [2:0]            r_ek;
    // stage F: normal times depth
    logic                  r_fv;
    logic                  r_fhit;
    logic signed [DQW-1:0] r_fdq;
    logic signed [PW-1:0]  r_fplo [3];
    logic signed [PW-1:0]  r_fphi [3];
    logic signed [COW-1:0] r_fcor [3];
    logic [2:0]            r_fk;
    // stage G: finished corner
    logic    r_gv;
    logic    r_gend;
    t_result r_g;
    // emitter
    logic    r_pv, r_pfl, r_ov;
    t_result r_pend, r_out;
    logic    n_pv, n_pfl, n_ov;
    t_result n_pend, n_out;

    logic signed [15:0]    nv [3];
    logic signed [31:0]    pp [3];
    logic signed [FW-1:0]  c_full [3];
    logic signed [COW-1:0] c_cor [3];
    logic signed [COW:0]   d_diff [3];
    logic signed [DQW-1:0] f_dq;
    logic signed [SW-1:0]  g_sum [3];
    logic signed [SATW-1:0] g_con [3];
    logic [31:0]           g_sat [3];

    assign nv[0] = i_plane.nx;
    assign nv[1] = i_plane.ny;
    assign nv[2] = i_plane.nz;
    assign pp[0] = i_plane.px;
    assign pp[1] = i_plane.py;
    assign pp[2] = i_plane.pz;

    assign en    = consume || !r_gv;
    assign issue = en && !i_stat.empty;
    assign o_pop = issue && (r_k == LAST_CORNER);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_full[i] = (FW'(r_bph[i]) <<< 16) + FW'(r_bpl[i]);
            c_cor[i]  = COW'($signed(r_bctr[i])) + COW'($signed(c_full[i][FW-1:28]));
            d_diff[i] = (COW+1)'(pp[i]) - (COW+1)'(r_ccor[i]);
            g_sum[i]  = (SW'(r_fphi[i]) <<< LOW) + SW'(r_fplo[i]);
            g_con[i]  = SATW'(r_fcor[i]) + SATW'($signed(g_sum[i][SW-1:14]));
            g_sat[i]  = f_sat32(g_con[i]);
        end
        f_dq = r_ed[DW-1:14];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k  <= '0;
            r_av <= 1'b0;
            r_bv <= 1'b0;
            r_cv <= 1'b0;
            r_dv <= 1'b0;
            r_ev <= 1'b0;
            r_fv <= 1'b0;
            r_gv <= 1'b0;
        end else if (en) begin
            if (issue) begin
                r_k <= r_k + 1'b1;
            end
            r_av <= issue;
            r_bv <= r_av;
            r_cv <= r_bv;
            r_dv <= r_cv;
            r_ev <= r_dv;
            r_fv <= r_ev;
            r_gv <= r_fv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_ac[i] <= f_sgn(i_job.m[3*i], r_k[0]) + f_sgn(i_job.m[3*i+1], r_k[1])
                         + f_sgn(i_job.m[3*i+2], r_k[2]);
                r_bph[i] <= r_ac[i] * $signed({1'b0, r_ah[30:16]});
                r_bpl[i] <= r_ac[i] * $signed({1'b0, r_ah[15:0]});
                r_ccor[i] <= c_cor[i];
                r_dm[i]   <= d_diff[i] * nv[i];
                r_dcor[i] <= r_ccor[i];
                r_ecor[i] <= r_dcor[i];
                r_fplo[i] <= nv[i] * $signed({1'b0, f_dq[LOW-1:0]});
                r_fphi[i] <= nv[i] * $signed(f_dq[DQW-1:LOW]);
                r_fcor[i] <= r_ecor[i];
            end
            r_actr <= i_job.ctr;
            r_ah   <= i_job.half;
            r_ak   <= r_k;
            r_bctr <= r_actr;
            r_bk   <= r_ak;
            r_ck   <= r_bk;
            r_dk   <= r_ck;
            r_ed   <= DW'(r_dm[0]) + DW'(r_dm[1]) + DW'(r_dm[2]);
            r_ek   <= r_dk;
            r_fhit <= (r_ed > 0);
            r_fdq  <= f_dq;
            r_fk   <= r_ek;
            r_g.hit    <= r_fhit;
            r_g.corner <= r_fk;
            r_g.cx     <= g_sat[0];
            r_g.cy     <= g_sat[1];
            r_g.cz     <= g_sat[2];
            r_g.depth  <= (|r_fdq[DQW-1:31]) ? 31'h7fffffff : r_fdq[30:0];
            r_g.last   <= 1'b0;
            r_gend     <= (r_fk == LAST_CORNER);
        end
    end

    always_comb begin
        o_free  = !r_ov || i_ready;
        n_ov    = r_ov && !i_ready;
        n_out   = r_out;
        n_pv    = r_pv;
        n_pfl   = r_pfl;
        n_pend  = r_pend;
        consume = 1'b0;
        if (r_pv && r_pfl) begin
            if (o_free) begin
                n_ov       = 1'b1;
                n_out      = r_pend;
                n_out.last = 1'b1;
                n_pv       = 1'b0;
                n_pfl      = 1'b0;
                // next box's corner moves on while the final beat leaves
                if (r_gv) begin
                    if (r_g.hit) begin
                        n_pv    = 1'b1;
                        n_pend  = r_g;
                        n_pfl   = r_gend;
                        consume = 1'b1;
                    end else if (!r_gend) begin
                        consume = 1'b1;
                    end
                end
            end
        end else if (r_gv) begin
            if (r_g.hit) begin
                if (r_pv) begin
                    if (o_free) begin
                        n_ov       = 1'b1;
                        n_out      = r_pend;
                        n_out.last = 1'b0;
                        n_pend     = r_g;
                        n_pfl      = r_gend;
                        consume    = 1'b1;
                    end
                end else begin
                    n_pv    = 1'b1;
                    n_pend  = r_g;
                    n_pfl   = r_gend;
                    consume = 1'b1;
                end
            end else if (r_gend) begin
                if (r_pv) begin
                    n_pfl   = 1'b1;
                    consume = 1'b1;
                end else if (o_free) begin
                    n_ov       = 1'b1;
                    n_out      = '0;
                    n_out.last = 1'b1;
                    consume    = 1'b1;
                end
            end else begin
                consume = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv  <= 1'b0;
            r_pfl <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            r_pv  <= n_pv;
            r_pfl <= n_pfl;
            r_ov  <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign o_valid = r_ov;
    assign o_res   = r_out;

endmodule

>>> test/plane_box_corner_contacts_unit_test.sv
// ----------------------------------------------------------------------------
// plane_box_corner_contacts_unit_test
// Self-checking bench for the plane/box corner contact unit: boxes are
// streamed in under random backpressure, each plane setting is written over
// APB while the unit is idle, and every contact beat is compared against a
// locally computed corner contact list.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module plane_box_corner_contacts_unit_test;
    import pbcc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 24;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         m_tlast;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    plane_box_corner_contacts_unit u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    logic [191:0] box_q[$];
    t_result      contact_q[$];
    int           src_idle;
    int           snk_idle;
    int           errors;
    int           cycles;
    logic         box_taken;

    logic signed [31:0] plane_px, plane_py, plane_pz;
    logic signed [15:0] plane_nx, plane_ny, plane_nz;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [31:0] clamp32(input logic signed [127:0] v);
        if (v > 128'sd2147483647) return 32'h7fffffff;
        if (v < -128'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic void predict_contacts(input logic [191:0] b);
        logic signed [127:0] ctr[3];
        logic signed [127:0] pp[3];
        logic signed [127:0] nv[3];
        logic signed [127:0] m[9];
        logic signed [127:0] sg[3];
        logic signed [127:0] cor[3];
        logic signed [127:0] h, w, x, y, z, one, c, d, dq;
        t_result r;
        t_result hits[$];
        ctr[0] = $signed(b[31:0]);
        ctr[1] = $signed(b[63:32]);
        ctr[2] = $signed(b[95:64]);
        h = {97'd0, b[126:96]};
        w = $signed(b[142:127]);
        x = $signed(b[158:143]);
        y = $signed(b[174:159]);
        z = $signed(b[190:175]);
        pp[0] = plane_px; pp[1] = plane_py; pp[2] = plane_pz;
        nv[0] = plane_nx; nv[1] = plane_ny; nv[2] = plane_nz;
        one = 128'sd1 <<< 28;
        m[0] = one - 2 * (y * y + z * z);
        m[1] = 2 * (x * y - w * z);
        m[2] = 2 * (x * z + w * y);
        m[3] = 2 * (x * y + w * z);
        m[4] = one - 2 * (x * x + z * z);
        m[5] = 2 * (y * z - w * x);
        m[6] = 2 * (x * z - w * y);
        m[7] = 2 * (y * z + w * x);
        m[8] = one - 2 * (x * x + y * y);
        for (int k = 0; k < 8; k++) begin
            for (int j = 0; j < 3; j++)
                sg[j] = ((k >> j) & 1) ? -128'sd1 : 128'sd1;
            d = 0;
            for (int i = 0; i < 3; i++) begin
                c = sg[0] * m[3*i] + sg[1] * m[3*i+1] + sg[2] * m[3*i+2];
                cor[i] = ctr[i] + ((c * h) >>> 28);
                d = d + (pp[i] - cor[i]) * nv[i];
            end
            if (d > 0) begin
                dq = d >>> 14;
                r.hit = 1'b1;
                r.corner = 3'(k);
                r.cx = clamp32(cor[0] + ((nv[0] * dq) >>> 14));
                r.cy = clamp32(cor[1] + ((nv[1] * dq) >>> 14));
                r.cz = clamp32(cor[2] + ((nv[2] * dq) >>> 14));
                r.depth = (dq > 128'sd2147483647) ? 31'h7fffffff : dq[30:0];
                r.last = 1'b0;
                hits.insert(hits.size(), r);
            end
        end
        if (hits.size() == 0) begin
            r = '0;
            r.last = 1'b1;
            hits.insert(hits.size(), r);
        end else begin
            hits[hits.size()-1].last = 1'b1;
        end
        foreach (hits[i]) contact_q.insert(contact_q.size(), hits[i]);
    endfunction

    // monitor
    always @(posedge i_clk) begin
        t_result got, want;
        box_taken = s_tvalid && s_tready;
        if (i_rst_n && box_taken) predict_contacts(s_tdata);
        if (i_rst_n && m_tvalid && m_tready) begin
            got.hit = m_tuser[0];
            got.corner = m_tdata[2:0];
            got.cx = m_tdata[34:3];
            got.cy = m_tdata[66:35];
            got.cz = m_tdata[98:67];
            got.depth = m_tdata[129:99];
            got.last = m_tlast;
            if (contact_q.size() == 0) begin
                $error("unexpected contact beat");
                errors++;
            end else begin
                want = contact_q.pop_front();
                if (got.hit !== want.hit) begin
                    $error("hit exp %0d got %0d", want.hit, got.hit); errors++;
                end
                if (got.corner !== want.corner) begin
                    $error("corner exp %0d got %0d", want.corner, got.corner); errors++;
                end
                if (got.cx !== want.cx) begin
                    $error("contact_x exp %0d got %0d", want.cx, got.cx); errors++;
                end
                if (got.cy !== want.cy) begin
                    $error("contact_y exp %0d got %0d", want.cy, got.cy); errors++;
                end
                if (got.cz !== want.cz) begin
                    $error("contact_z exp %0d got %0d", want.cz, got.cz); errors++;
                end
                if (got.depth !== want.depth) begin
                    $error("depth exp %0d got %0d", want.depth, got.depth); errors++;
                end
                if (got.last !== want.last) begin
                    $error("last exp %0d got %0d", want.last, got.last); errors++;
                end
            end
        end
    end

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!s_tvalid || box_taken) begin
                if (box_q.size() > 0 && $urandom_range(99) >= src_idle) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= box_q.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= snk_idle);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = 5'(idx) << 2;
        pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        case (idx)
            REG_PX: plane_px = val;
            REG_PY: plane_py = val;
            REG_PZ: plane_pz = val;
            REG_NX: plane_nx = val[15:0];
            REG_NY: plane_ny = val[15:0];
            REG_NZ: plane_nz = val[15:0];
            default: ;
        endcase
    endtask

    task automatic set_plane(input logic [31:0] px, py, pz, input logic [15:0] nx, ny, nz);
        write_reg(REG_PX, px);
        write_reg(REG_PY, py);
        write_reg(REG_PZ, pz);
        write_reg(REG_NX, {16'd0, nx});
        write_reg(REG_NY, {16'd0, ny});
        write_reg(REG_NZ, {16'd0, nz});
    endtask

    task automatic add_box(input logic [31:0] cx, cy, cz, input logic [30:0] hs,
                           input logic [15:0] qw, qx, qy, qz);
        box_q.insert(box_q.size(), {1'b0, qz, qy, qx, qw, hs, cz, cy, cx});
    endtask

    // boxes that straddle the plane more often than not
    task automatic add_random_boxes(input int n);
        logic [31:0] c[3];
        logic [30:0] hs;
        logic [15:0] q[4];
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) < 2) begin
                foreach (c[j]) c[j] = $urandom;
                hs = 31'($urandom);
                foreach (q[j]) q[j] = 16'($urandom);
            end else begin
                foreach (c[j]) c[j] = 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
                hs = 31'($urandom_range(0, 3 << 16));
                foreach (q[j]) q[j] = 16'($signed($urandom_range(0, 32768)) - 16384);
            end
            add_box(c[0], c[1], c[2], hs, q[0], q[1], q[2], q[3]);
        end
    endtask

    task automatic drain();
        while (box_q.size() > 0 || contact_q.size() > 0 || s_tvalid) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        cycles = 0;
        box_taken = 1'b0;
        src_idle = 33;
        snk_idle = 33;
        plane_px = 0; plane_py = 0; plane_pz = 0;
        plane_nx = 0; plane_ny = 16'sd16384; plane_nz = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset plane, written back explicitly
        set_plane(0, 0, 0, 16'd0, 16'd16384, 16'd0);
        add_box(0, 0, 0, 31'd0, 16'd16384, 0, 0, 0);
        add_box(0, 32'h0000_8000, 0, 31'h0001_0000, 16'd16384, 0, 0, 0);
        add_box(0, 32'hfff0_0000, 0, 31'h0001_0000, 16'd16384, 0, 0, 0);
        add_box(0, 32'h0010_0000, 0, 31'h0001_0000, 16'd16384, 0, 0, 0);
        add_box(0, 32'h0001_0000, 0, 31'h0001_0000, 16'd16384, 0, 0, 0);
        add_box(0, 32'h0000_0001, 0, 31'h0000_0001, 16'd16384, 0, 0, 0);
        add_box(0, 0, 0, 31'h0001_0000, 16'd11585, 16'd11585, 0, 0);
        add_box(0, 0, 0, 31'h0001_0000, 16'd11585, 0, 0, 16'd11585);
        add_box(0, 0, 0, 31'h0001_0000, 16'd8192, 16'd8192, 16'd8192, 16'd8192);
        add_box(0, 0, 0, 31'h0001_0000, 0, 0, 0, 0);
        add_box(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff,
                16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        add_box(32'h80000000, 32'h80000000, 32'h80000000, 31'h7fffffff,
                16'h8000, 16'h8000, 16'h8000, 16'h8000);
        add_box(32'h80000000, 32'h7fffffff, 32'h80000000, 31'h7fffffff,
                16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
        add_box(32'hffffffff, 32'hffffffff, 32'hffffffff, 31'h7fffffff,
                16'hffff, 16'hffff, 16'hffff, 16'hffff);
        add_box(0, 0, 0, 31'h4000_0000, 16'd16384, 0, 0, 0);
        add_random_boxes(40);
        drain();

        // extreme plane, no idling at all
        src_idle = 0;
        snk_idle = 0;
        set_plane(32'h7fffffff, 32'h80000000, 32'h7fffffff, 16'h8000, 16'h7fff, 16'h8000);
        add_box(0, 0, 0, 31'h7fffffff, 16'd16384, 0, 0, 0);
        add_box(32'h7fffffff, 32'h80000000, 0, 31'h0100_0000, 16'd16384, 0, 0, 0);
        add_random_boxes(50);
        drain();

        src_idle = 33;
        snk_idle = 33;
        set_plane(0, 0, 32'h0000_8000, 16'd0, 16'd0, 16'd16384);
        add_random_boxes(60);
        drain();

        set_plane(32'h80000000, 32'h80000000, 32'h80000000, 16'h8000, 16'h8000, 16'h8000);
        add_random_boxes(30);
        drain();

        set_plane($urandom_range(0, 1 << 17), $urandom_range(0, 1 << 17), 0,
                  16'd9459, 16'($signed(-9459)), 16'd9459);
        add_random_boxes(83);
        drain();

        if (contact_q.size() != 0) begin
            $error("contact beats still expected at end");
            errors++;
        end
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
